// ===== design/epoch_seconds_to_calendar_assert.svh =====
// Assertion macros shared by the calendar conversion modules.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`ifndef SYNTH
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/esc_pkg.sv =====
// Types, constants and the month length table of the calendar conversion.
package esc_pkg;

  localparam logic [10:0] BASE_YEAR   = 11'd1970;
  localparam logic [15:0] ZONE_RESET  = 16'd28800;
  localparam logic [31:0] SEC_MINUTE  = 32'd60;
  localparam logic [31:0] SEC_HOUR    = 32'd3600;
  localparam logic [31:0] SEC_DAY     = 32'd86400;
  localparam logic [31:0] SEC_YEAR    = 32'd31536000;
  localparam logic [31:0] SEC_LEAPYR  = 32'd31622400;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_APR   = 4'd4;
  localparam logic [3:0]  MONTH_JUN   = 4'd6;
  localparam logic [3:0]  MONTH_SEP   = 4'd9;
  localparam logic [3:0]  MONTH_NOV   = 4'd11;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;

  typedef enum logic [2:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   step;
    logic   publish;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic less;
    logic month_last;
  } stat_t;

  function automatic logic [21:0] month_seconds(logic [3:0] month, logic leap);
    logic [21:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 22'd2592000;
      MONTH_FEB: len = leap ? 22'd2505600 : 22'd2419200;
      default:   len = 22'd2678400;
    endcase
    return len;
  endfunction

endpackage

// ===== design/esc_datapath.sv =====
// Datapath: remaining-seconds register, field counters, output registers.
`include "epoch_seconds_to_calendar_assert.svh"
module esc_datapath import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [15:0] zone_offset_seconds_i,
  input  logic [30:0] epoch_seconds_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [10:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [15:0] zone_q;
  logic [31:0] t_q, t_d;
  logic [10:0] year_q, year_d;
  logic [6:0]  yr_in_cent_q, yr_in_cent_d;
  logic [1:0]  cent_mod4_q, cent_mod4_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic        leap;
  logic [31:0] len;

  // Leap test kept cheap by tracking year modulo 100 and century modulo 4.
  assign leap = (year_q[1:0] == 2'd0) && ((yr_in_cent_q != 7'd0) || (cent_mod4_q == 2'd0));

  always_comb begin
    case (cmd_i.phase)
      PH_YEAR:  len = leap ? SEC_LEAPYR : SEC_YEAR;
      PH_MONTH: len = {10'd0, month_seconds(month_q, leap)};
      PH_DAY:   len = SEC_DAY;
      PH_HOUR:  len = SEC_HOUR;
      default:  len = SEC_MINUTE;
    endcase
  end

  assign stat_o.less       = t_q < len;
  assign stat_o.month_last = month_q == MONTH_DEC;

  always_comb begin
    t_d          = t_q;
    year_d       = year_q;
    yr_in_cent_d = yr_in_cent_q;
    cent_mod4_d  = cent_mod4_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    if (cmd_i.load) begin
      t_d          = {1'b0, epoch_seconds_i} + {16'd0, zone_q};
      year_d       = BASE_YEAR;
      yr_in_cent_d = 7'd70;
      cent_mod4_d  = 2'd3;
      month_d      = 4'd1;
      day_d        = 5'd1;
      hour_d       = 5'd0;
      minute_d     = 6'd0;
    end else if (cmd_i.step) begin
      t_d = t_q - len;
      case (cmd_i.phase)
        PH_YEAR: begin
          year_d = year_q + 11'd1;
          if (yr_in_cent_q == 7'd99) begin
            yr_in_cent_d = 7'd0;
            cent_mod4_d  = cent_mod4_q + 2'd1;
          end else begin
            yr_in_cent_d = yr_in_cent_q + 7'd1;
          end
        end
        PH_MONTH: month_d  = month_q + 4'd1;
        PH_DAY:   day_d    = day_q + 5'd1;
        PH_HOUR:  hour_d   = hour_q + 5'd1;
        default:  minute_d = minute_q + 6'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q       <= ZONE_RESET;
      year_q       <= BASE_YEAR;
      yr_in_cent_q <= 7'd70;
      cent_mod4_q  <= 2'd3;
      month_q      <= 4'd1;
      day_q        <= 5'd1;
      hour_q       <= 5'd0;
      minute_q     <= 6'd0;
    end else begin
      if (cfg_valid_i) begin
        zone_q <= zone_offset_seconds_i;
      end
      year_q       <= year_d;
      yr_in_cent_q <= yr_in_cent_d;
      cent_mod4_q  <= cent_mod4_d;
      month_q      <= month_d;
      day_q        <= day_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (cmd_i.publish) begin
      year_o   <= year_q;
      month_o  <= month_q;
      day_o    <= day_q;
      hour_o   <= hour_q;
      minute_o <= minute_q;
      second_o <= t_q[5:0];
    end
  end

  `ESC_ASSERT(a_month_range, clk_i, rst_ni, (month_q != 4'd0) && (month_q <= MONTH_DEC), "month counter out of range")
  `ESC_ASSERT(a_clock_range, clk_i, rst_ni, (hour_q <= 5'd23) && (minute_q <= 6'd59), "hour or minute counter out of range")
  `ESC_ASSERT(a_second_fits, clk_i, rst_ni, cmd_i.publish |-> (t_q < SEC_MINUTE), "remainder too large at publish")

endmodule

// ===== design/esc_ctrl.sv =====
// Controller: sequences the subtraction phases and owns both handshakes.
`include "epoch_seconds_to_calendar_assert.svh"
module esc_ctrl import esc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MINUTE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    cmd_o.phase   = PH_MINUTE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd_o.phase = PH_YEAR;
        if (stat_i.less) state_d = S_MONTH;
        else cmd_o.step = 1'b1;
      end
      S_MONTH: begin
        cmd_o.phase = PH_MONTH;
        if (stat_i.less || stat_i.month_last) state_d = S_DAY;
        else cmd_o.step = 1'b1;
      end
      S_DAY: begin
        cmd_o.phase = PH_DAY;
        if (stat_i.less) state_d = S_HOUR;
        else cmd_o.step = 1'b1;
      end
      S_HOUR: begin
        cmd_o.phase = PH_HOUR;
        if (stat_i.less) state_d = S_MINUTE;
        else cmd_o.step = 1'b1;
      end
      S_MINUTE: begin
        cmd_o.phase = PH_MINUTE;
        if (stat_i.less) state_d = S_FINISH;
        else cmd_o.step = 1'b1;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ESC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "took a second item while converting")
  `ESC_ASSERT(a_step_only_when_fits, clk_i, rst_ni, cmd_o.step |-> !stat_i.less, "subtracted a length larger than the remainder")
  `ESC_ASSERT(a_publish_sets_valid, clk_i, rst_ni, cmd_o.publish |=> out_valid_o, "publish did not raise output valid")
  `ESC_ASSERT_ALWAYS(a_one_command, clk_i, !(cmd_o.load && (cmd_o.step || cmd_o.publish)), "conflicting datapath commands")

endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
// Top level: converts epoch seconds plus a zone offset to local date and time.
//
//  channel   direction  signals                                  transfer when
//  cfg       in         cfg_valid_i/cfg_ready_o, zone offset     valid and ready high
//  in        in         in_valid_i/in_ready_o, epoch_seconds_i   valid and ready high
//  out       out        out_valid_o/out_ready_i, year..second    valid and ready high
//
// One item passes through a load, one step per whole year, month, day, hour
// and minute removed by the single subtractor, one closing step in each of the five
// phases, and a last step that moves the fields into the output register.
// Reset sets the zone offset to eight hours and empties the output register.
// A stalled output holds back the next publish, and no new input transfer goes ahead until then.
// The configuration register is always ready and takes the offset on each write transfer.
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] zone_offset_seconds_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  cmd_t  cmd;
  stat_t stat;

  // The offset register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  esc_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .zone_offset_seconds_i (zone_offset_seconds_i),
    .epoch_seconds_i       (epoch_seconds_i),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_o                 (day_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o)
  );

endmodule

// ===== dv/tb_epoch_seconds_to_calendar.sv =====
// Self-checking testbench for the epoch seconds to local calendar converter.
module tb_epoch_seconds_to_calendar;
  import esc_pkg::*;

  // The limit lies well beyond the slowest correct item plus the longest receiver
  // hold, so a quiet stretch this long can only mean a hang.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Extra cycles after the last result, enough for a stray result to show up.
  localparam int unsigned SETTLE_CYCLES  = 250;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int unsigned MAX_REPORTS    = 40;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] zone_offset_seconds_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [30:0] epoch_seconds_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [10:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  // Dates predicted for accepted inputs, oldest first.
  calendar_t   pending_dates[$];
  // Our copy of the zone offset register, updated when a write transfer completes.
  logic [15:0] zone_offset_q = ZONE_RESET;
  int unsigned mismatch_count = 0;
  // Random gaps on both channels are allowed only while this is set.
  bit          idle_en = 1'b1;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned hold_request = 0;

  epoch_seconds_to_calendar i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .zone_offset_seconds_i (zone_offset_seconds_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .epoch_seconds_i       (epoch_seconds_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .year_o                (year_o),
    .month_o               (month_o),
    .day_o                 (day_o),
    .hour_o                (hour_o),
    .minute_o              (minute_o),
    .second_o              (second_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic used for prediction and for aiming stimulus at dates.
  // ---------------------------------------------------------------------------

  // Full Gregorian rule: every 400th year is leap, other centuries are not.
  function automatic bit leap_year(int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(int unsigned yr, logic [3:0] mon);
    int unsigned n;
    case (mon)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
      MONTH_FEB: n = leap_year(yr) ? 29 : 28;
      default:   n = 31;
    endcase
    return n;
  endfunction

  // Local date and time for a count of UTC seconds and a zone offset. The sum is
  // kept in 64 bits, so the top of the input range plus any offset is exact.
  function automatic calendar_t calendar_of(logic [30:0] secs, logic [15:0] zone);
    calendar_t       c;
    longint unsigned rest;
    longint unsigned span;
    int unsigned     yr;
    logic [3:0]      mon;
    rest = 64'(secs) + 64'(zone);
    yr   = BASE_YEAR;
    span = 64'(days_in_year(yr)) * SEC_DAY;
    while (rest >= span) begin
      rest -= span;
      yr++;
      span = 64'(days_in_year(yr)) * SEC_DAY;
    end
    // December is never stepped past; whatever is left belongs to it.
    mon  = 4'd1;
    span = 64'(days_in_month(yr, mon)) * SEC_DAY;
    while (mon < MONTH_DEC && rest >= span) begin
      rest -= span;
      mon++;
      span = 64'(days_in_month(yr, mon)) * SEC_DAY;
    end
    c.year   = 11'(yr);
    c.month  = mon;
    c.day    = 5'(rest / SEC_DAY + 1);
    rest     = rest % SEC_DAY;
    c.hour   = 5'(rest / SEC_HOUR);
    rest     = rest % SEC_HOUR;
    c.minute = 6'(rest / SEC_MINUTE);
    c.second = 6'(rest % SEC_MINUTE);
    return c;
  endfunction

  // Seconds from 1970-01-01 00:00:00 to midnight starting the given local date.
  function automatic longint midnight_of(int unsigned yr, int unsigned mon, int unsigned dom);
    longint days;
    days = 0;
    for (int unsigned y = BASE_YEAR; y < yr; y++) days += days_in_year(y);
    for (int unsigned m = 1; m < mon; m++) days += days_in_month(yr, 4'(m));
    days += dom - 1;
    return days * SEC_DAY;
  endfunction

  // Random epoch value. Four in ten values are aimed at a local date under the
  // current offset, most within three seconds of a day, month or year boundary,
  // where the year and month walks have to stop at exactly the right place.
  function automatic logic [30:0] random_epoch();
    longint      stamp;
    int unsigned yr;
    int unsigned mon;
    int unsigned dom;
    int unsigned tod;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: stamp = longint'(31'($urandom()));
      8: stamp = longint'(31'($urandom()) & ((31'd1 << $urandom_range(1, 30)) - 31'd1));
      9: stamp = 64'd2147483647 - $urandom_range(0, 200000);
      default: begin
        yr  = $urandom_range(1970, 2038);
        mon = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
          0:       dom = 1;
          1:       dom = days_in_month(yr, 4'(mon));
          default: dom = $urandom_range(1, days_in_month(yr, 4'(mon)));
        endcase
        case ($urandom_range(0, 2))
          0:       tod = 0;
          1:       tod = SEC_DAY - 1;
          default: tod = $urandom_range(0, SEC_DAY - 1);
        endcase
        stamp = midnight_of(yr, mon, dom) + tod + $urandom_range(0, 6) - 3 - zone_offset_q;
      end
    endcase
    if (stamp < 0) stamp = 0;
    if (stamp > 64'd2147483647) stamp = 64'd2147483647;
    return 31'(stamp);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks.
  // ---------------------------------------------------------------------------

  // Offers one epoch value, sometimes after a short gap, and keeps it on the bus
  // until the input transfer completes. The prediction uses the offset in force
  // at that moment.
  task automatic send_epoch(input logic [30:0] secs);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(calendar_of(secs, zone_offset_q));
  endtask

  // Stops offering input and waits until every predicted date has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
  endtask

  // Writes the zone offset once the converter has gone idle.
  task automatic set_zone(input logic [15:0] zone);
    wait_drained();
    cfg_valid_i           <= 1'b1;
    zone_offset_seconds_i <= zone;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    zone_offset_q  = zone;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_date(input calendar_t got);
    calendar_t want;
    if (pending_dates.size() == 0) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
      mismatch_count++;
    end else begin
      want = pending_dates.pop_front();
      compare_field("year",   want.year,   got.year);
      compare_field("month",  want.month,  got.month);
      compare_field("day",    want.day,    got.day);
      compare_field("hour",   want.hour,   got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
    end
  endtask

  // Receiver: checks each output transfer and drives ready. Ready drops in random
  // bursts while idling is enabled, and for a long stretch when a hold is asked
  // for, so the converter backs up into its input.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        check_date({year_o, month_o, day_o, hour_o, minute_o, second_o});
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The offset after reset is eight hours; the local day rolls over eight hours
  // early in UTC terms.
  task automatic test_reset_offset();
    send_epoch(31'd0);
    send_epoch(31'd57599);
    send_epoch(31'd57600);
    send_epoch(31'h7FFFFFFF);
  endtask

  // With no offset, the inputs are calendar boundaries in UTC: minute, hour, day,
  // month and year rollovers, the last second of a common February, the leap days
  // of 1972 and 2000 (a year divisible by 400), the last day of a leap year and
  // the largest input.
  task automatic test_calendar_edges();
    logic [30:0] boundary_secs [15] = '{
      31'd0, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400, 31'd2678399,
      31'd31535999, 31'd31536000, 31'd36633599, 31'd68169600, 31'd951782400,
      31'd978307199, 31'h7FFFFFFF
    };
    set_zone(16'd0);
    foreach (boundary_secs[i]) send_epoch(boundary_secs[i]);
  endtask

  // The largest offset the register holds is used as written, beyond the usual
  // range; the sum with the largest input still ends in 2038.
  task automatic test_offset_extremes();
    set_zone(16'hFFFF);
    send_epoch(31'd0);
    send_epoch(31'h7FFFFFFF);
    send_epoch(31'h55555555);
    send_epoch(31'h2AAAAAAA);
    set_zone(16'd50400);
    send_epoch(31'd0);
    send_epoch(31'h7FFFFFFF);
  endtask

  // Segments of random inputs under several offsets, extremes included. One
  // segment runs without gaps on either side.
  task automatic test_random_offsets();
    logic [15:0] zones [7];
    zones = '{16'd0, 16'hFFFF, 16'd50400, ZONE_RESET, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 50400)), 16'($urandom_range(0, 65535))};
    foreach (zones[s]) begin
      set_zone(zones[s]);
      idle_en = (s != 3);
      repeat (200) send_epoch(random_epoch());
    end
    idle_en = 1'b1;
  endtask

  // The receiver is asked to hold off while inputs keep coming, so the converter
  // fills and stalls its input; then the sender stops until every result is out.
  task automatic test_output_backpressure();
    set_zone(16'($urandom_range(0, 50400)));
    repeat (3) begin
      hold_request = $urandom_range(300, 500);
      repeat (10) send_epoch(random_epoch());
      wait_drained();
    end
    repeat (20) send_epoch(random_epoch());
  endtask

  // Back-to-back inputs with the receiver always ready, to close the run.
  task automatic test_full_rate();
    idle_en = 1'b0;
    set_zone(16'($urandom_range(0, 65535)));
    repeat (430) send_epoch(random_epoch());
  endtask

  initial begin
    rst_ni                <= 1'b0;
    cfg_valid_i           <= 1'b0;
    zone_offset_seconds_i <= '0;
    in_valid_i            <= 1'b0;
    epoch_seconds_i       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_offset();
    test_calendar_edges();
    test_offset_extremes();
    test_random_offsets();
    test_output_backpressure();
    test_full_rate();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
